// ----- rtl/core/tkf_pkg.sv -----
// Shared constants and types for the top-k frequency tracker.
package tkf_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VAL_W         = 64;

  // Request codes
  localparam logic REQ_OFFER = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Result kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LIST   = 1'b1;

  typedef logic [VAL_W-1:0] val_t;

  // Per-cycle command broadcast to every cell of the table
  typedef struct packed {
    logic offer;   // an offer word is accepted this cycle
    logic shift;   // the offer evicts slot 0 and moves the lower slots down
    logic rotate;  // readout: move every slot up by one, wrapping the top to slot 0
  } cmd_t;

endpackage

// ----- rtl/core/tkf_if.sv -----
// Valid/ready channel interfaces for offer/readout requests and results.
interface tkf_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  tkf_pkg::val_t     freq;
  tkf_pkg::val_t     key_id;

  modport source (output valid, output req_type, output freq, output key_id, input ready);
  modport sink   (input valid, input req_type, input freq, input key_id, output ready);
endinterface

interface tkf_rsp_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              entry_valid;
  tkf_pkg::val_t     counter;
  tkf_pkg::val_t     entry_key;
  tkf_pkg::val_t     samples_seen;
  logic              last;

  modport source (output valid, output kind, output entry_valid, output counter,
                  output entry_key, output samples_seen, output last, input ready);
  modport sink   (input valid, input kind, input entry_valid, input counter,
                  input entry_key, input samples_seen, input last, output ready);
endinterface

// ----- rtl/core/tkf_cell.sv -----
// One slot of the sorted table: counter, key and its local compare.
module tkf_cell (
  input  logic          clk,
  input  logic          rst,
  input  tkf_pkg::cmd_t cmd,
  input  tkf_pkg::val_t freq,
  input  tkf_pkg::val_t key_id,
  input  logic          prefix_in,
  input  logic          upper_prefix,
  input  tkf_pkg::val_t upper_count,
  input  tkf_pkg::val_t upper_key,
  input  tkf_pkg::val_t lower_count,
  input  tkf_pkg::val_t lower_key,
  output tkf_pkg::val_t count,
  output tkf_pkg::val_t key,
  output logic          prefix_out,
  output logic          sel,
  output logic          shift_hit
);

  // All slots from 0 up to here are below the offered frequency
  assign prefix_out = prefix_in && (freq > count);
  // This is the highest such slot
  assign sel        = prefix_out && !upper_prefix;
  assign shift_hit  = sel && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.rotate) begin
      count <= lower_count;
    end else if (cmd.offer) begin
      if (sel) begin
        count <= freq;
      end else if (cmd.shift && upper_prefix) begin
        count <= upper_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rotate) begin
      key <= lower_key;
    end else if (cmd.offer) begin
      if (sel) begin
        key <= key_id;
      end else if (cmd.shift && upper_prefix) begin
        key <= upper_key;
      end
    end
  end

endmodule

// ----- rtl/core/top_k_frequency_tracker.sv -----
// Top level of the top-k frequency tracker: cell chain, readout walk and result register.
//
// Channels: req (sink) takes offer words (req_type 0: freq, key_id) and readout
// words (req_type 1); rsp (source) gives result words. Both use valid/ready and a
// word moves at a rising edge with valid and ready high.
// On an offer every cell compares freq with its own counter in parallel, a one-bit
// "all below" flag ripples up the chain and picks the slot, and the table is written
// at the edge that takes the offer. An insertion's report sits in the result
// register in the cycle after the offer; a dropped offer gives no word but still
// counts as a sample. Offers can follow one another in every cycle while the
// result register drains.
// A readout walks the table by rotating the whole chain up by one slot per cycle
// while the result register can take a word, reading the top cell, until every
// slot has been at the top once, so the table ends as it was. No request is
// taken during the walk. Its words run from the largest counter down, last marks
// the final one, and an empty table gives one word with entry_valid 0.
// Reset (rst, synchronous) clears every counter, the sample count and the result
// valid flag; keys are undefined until written. When rsp.ready is low the result
// word holds and req.ready drops until it can move.
module top_k_frequency_tracker #(
  parameter int unsigned DEPTH = tkf_pkg::DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  tkf_req_if.sink   req,
  tkf_rsp_if.source rsp
);

  localparam int unsigned STEP_W = $clog2(DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DEPTH - 1);

  tkf_pkg::val_t cnt [DEPTH];
  tkf_pkg::val_t keys[DEPTH];
  logic [DEPTH-1:0] pre;
  logic [DEPTH-1:0] sel;
  logic [DEPTH-1:0] hit;

  tkf_pkg::cmd_t cmd;
  tkf_pkg::val_t sample_total;
  logic              reading;
  logic [STEP_W-1:0] step;

  logic out_free;
  logic req_acc;
  logic offer_acc;
  logic read_acc;
  logic insert;
  logic need_emit;
  logic advance;
  logic list_last;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned LO = (i == 0) ? DEPTH - 1 : i - 1;
    logic          prefix_in;
    logic          upper_prefix;
    tkf_pkg::val_t upper_count;
    tkf_pkg::val_t upper_key;

    if (i == 0) begin : g_bottom
      assign prefix_in = 1'b1;
    end else begin : g_mid
      assign prefix_in = pre[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper_prefix = 1'b0;
      assign upper_count  = '0;
      assign upper_key    = '0;
    end else begin : g_below
      assign upper_prefix = pre[i+1];
      assign upper_count  = cnt[i+1];
      assign upper_key    = keys[i+1];
    end

    tkf_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .freq         (req.freq),
      .key_id       (req.key_id),
      .prefix_in    (prefix_in),
      .upper_prefix (upper_prefix),
      .upper_count  (upper_count),
      .upper_key    (upper_key),
      .lower_count  (cnt[LO]),
      .lower_key    (keys[LO]),
      .count        (cnt[i]),
      .key          (keys[i]),
      .prefix_out   (pre[i]),
      .sel          (sel[i]),
      .shift_hit    (hit[i])
    );
  end

  // Handshake: hold off requests during a readout walk or while the result word is stuck
  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = !reading && out_free;
  assign req_acc   = req.valid && req.ready;
  assign offer_acc = req_acc && (req.req_type == tkf_pkg::REQ_OFFER);
  assign read_acc  = req_acc && (req.req_type == tkf_pkg::REQ_READ);
  // Slot 0 below freq means at least one slot takes the word
  assign insert    = offer_acc && pre[0];

  // Readout: the top cell shows the next slot; emit it if occupied, or on the
  // first step when the whole table is empty
  assign need_emit = (cnt[DEPTH-1] != '0) || (step == '0);
  assign advance   = reading && (!need_emit || out_free);
  assign list_last = (cnt[DEPTH-1] == '0) || (step == STEP_LAST) || (cnt[DEPTH-2] == '0);

  always_comb begin
    cmd        = '0;
    cmd.offer  = offer_acc;
    // Eviction only when the chosen slot is above slot 0 and already occupied
    cmd.shift  = |hit[DEPTH-1:1];
    cmd.rotate = advance;
  end

  // Sample count and readout walk
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total <= '0;
      reading      <= 1'b0;
      step         <= '0;
    end else begin
      if (offer_acc) begin
        sample_total <= sample_total + tkf_pkg::VAL_W'(1);
      end
      if (read_acc) begin
        reading <= 1'b1;
        step    <= '0;
      end else if (advance) begin
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          reading <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (insert || (advance && need_emit)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      rsp.kind         <= tkf_pkg::KIND_INSERT;
      rsp.entry_valid  <= 1'b1;
      rsp.counter      <= req.freq;
      rsp.entry_key    <= req.key_id;
      rsp.samples_seen <= sample_total + tkf_pkg::VAL_W'(1);
      rsp.last         <= 1'b1;
    end else if (advance && need_emit) begin
      rsp.kind         <= tkf_pkg::KIND_LIST;
      rsp.entry_valid  <= (cnt[DEPTH-1] != '0);
      rsp.counter      <= cnt[DEPTH-1];
      rsp.entry_key    <= (cnt[DEPTH-1] != '0) ? keys[DEPTH-1] : '0;
      rsp.samples_seen <= sample_total;
      rsp.last         <= list_last;
    end
  end

  // At most one slot takes an offered word
  a_single_slot: assert property (@(posedge clk) disable iff (rst)
    offer_acc |-> $onehot0(sel))
    else $error("more than one slot selected for an offer");

  // No request is taken during a readout walk
  a_walk_blocks: assert property (@(posedge clk) disable iff (rst)
    reading |-> !req.ready)
    else $error("request accepted during readout walk");

  // An insertion always leaves a report in the result register
  a_insert_report: assert property (@(posedge clk) disable iff (rst)
    insert |=> (rsp.valid && (rsp.kind == tkf_pkg::KIND_INSERT)))
    else $error("insertion without report");

  // The walk ends after its final rotation
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (advance && (step == STEP_LAST)) |=> !reading)
    else $error("readout walk overran the table");

endmodule

// ----- sim/tb_top_k_frequency_tracker.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the top-k frequency tracker: directed and random words.
module tb_top_k_frequency_tracker;

  localparam int unsigned   DEPTH       = tkf_pkg::DEPTH_DEFAULT;
  localparam int unsigned   IDLE_PCT    = 37;
  localparam int unsigned   CYCLE_LIMIT = 200000;
  localparam tkf_pkg::val_t FREQ_MAX    = '1;
  localparam tkf_pkg::val_t KEY_ONES    = '1;

  // One result word as the block should present it
  typedef struct {
    logic          kind;
    logic          entry_valid;
    tkf_pkg::val_t counter;
    tkf_pkg::val_t entry_key;
    tkf_pkg::val_t samples_seen;
    logic          last;
  } result_word_t;

  logic clk;
  logic rst;

  tkf_req_if req_ch();
  tkf_rsp_if rsp_ch();

  top_k_frequency_tracker #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow of the table, kept ascending like the block's own
  tkf_pkg::val_t shadow_counts [DEPTH];
  tkf_pkg::val_t shadow_keys   [DEPTH];
  tkf_pkg::val_t shadow_samples;
  result_word_t  pending_results[$];

  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  bit            steady_flow = 1'b0;  // set to hold both sides free of idling
  tkf_pkg::val_t rising_freq = 64'd40;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: well beyond the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic tkf_pkg::val_t rand_val();
    return {$urandom, $urandom};
  endfunction

  // Work out the words one accepted request causes and queue them in order.
  function automatic void predict_word(input logic rtype, input tkf_pkg::val_t freq,
                                       input tkf_pkg::val_t key);
    int unsigned  below;
    int unsigned  slot;
    int           i;
    bit           listed;
    result_word_t rw;
    if (rtype == tkf_pkg::REQ_OFFER) begin
      shadow_samples = shadow_samples + 64'd1;
      // Count the leading slots that the offer beats; stop at the first it does not
      below = 0;
      while (below < DEPTH && freq > shadow_counts[below])
        below++;
      if (below == 0)
        return;  // drop: not above the smallest counter
      slot = below - 1;
      // Evict slot 0 and move the beaten slots down, unless the target is free
      if (slot != 0 && shadow_counts[slot] != 0) begin
        for (i = 0; i < int'(slot); i++) begin
          shadow_counts[i] = shadow_counts[i+1];
          shadow_keys[i]   = shadow_keys[i+1];
        end
      end
      shadow_counts[slot] = freq;
      shadow_keys[slot]   = key;
      rw = '{tkf_pkg::KIND_INSERT, 1'b1, freq, key, shadow_samples, 1'b1};
      pending_results.push_back(rw);
    end else begin
      // Readout: occupied slots from the top down, table left untouched
      listed = 1'b0;
      for (i = DEPTH - 1; i >= 0; i--) begin
        if (shadow_counts[i] != 0) begin
          rw = '{tkf_pkg::KIND_LIST, 1'b1, shadow_counts[i], shadow_keys[i],
                 shadow_samples, 1'b0};
          pending_results.push_back(rw);
          listed = 1'b1;
        end
      end
      if (!listed) begin
        rw = '{tkf_pkg::KIND_LIST, 1'b0, 64'd0, 64'd0, shadow_samples, 1'b1};
        pending_results.push_back(rw);
      end else begin
        pending_results[pending_results.size()-1].last = 1'b1;
      end
    end
  endfunction

  function automatic void check_field(input string name, input tkf_pkg::val_t want,
                                      input tkf_pkg::val_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Receiver: hold ready low about IDLE_PCT percent of the time, unless steady_flow is set
  always @(negedge clk) begin
    if (rst)
      rsp_ch.ready <= 1'b0;
    else
      rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each word that moves on rsp with the oldest expectation
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word, expected none, got kind %0d counter %0h key %0h",
                 $time, rsp_ch.kind, rsp_ch.counter, rsp_ch.entry_key);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", tkf_pkg::val_t'(want.kind), tkf_pkg::val_t'(rsp_ch.kind));
        check_field("entry_valid", tkf_pkg::val_t'(want.entry_valid),
                    tkf_pkg::val_t'(rsp_ch.entry_valid));
        check_field("counter", want.counter, rsp_ch.counter);
        check_field("entry_key", want.entry_key, rsp_ch.entry_key);
        check_field("samples_seen", want.samples_seen, rsp_ch.samples_seen);
        check_field("last", tkf_pkg::val_t'(want.last), tkf_pkg::val_t'(rsp_ch.last));
      end
    end
  end

  // Offer or read out one word. Enter and leave at a falling edge; valid is
  // only lowered here when the sender idles, so it never toggles within a step.
  task automatic send_word(input logic rtype, input tkf_pkg::val_t freq,
                           input tkf_pkg::val_t key);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rtype;
    req_ch.freq     <= freq;
    req_ch.key_id   <= key;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    predict_word(rtype, freq, key);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected word has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do
      @(negedge clk);
    while (pending_results.size() != 0);
  endtask

  // An empty table answers a readout with a single invalid word
  task automatic test_empty_readout();
    send_word(tkf_pkg::REQ_READ, rand_val(), rand_val());
  endtask

  // Zero frequency is always dropped; then fill all slots, the maximum first and then
  // rising odd values, so that later offers land on a free slot or shift a partly filled table.
  task automatic test_fill_table();
    int i;
    send_word(tkf_pkg::REQ_OFFER, 64'd0, KEY_ONES);
    send_word(tkf_pkg::REQ_OFFER, FREQ_MAX, KEY_ONES);
    for (i = 0; i < DEPTH - 1; i++)
      send_word(tkf_pkg::REQ_OFFER, tkf_pkg::val_t'(2 * i + 1),
                (i == 0) ? 64'd0 : rand_val());
    send_word(tkf_pkg::REQ_READ, 64'd0, 64'd0);
  endtask

  // With a full table: overwrite the smallest slot in place, then offers equal
  // to and below the smallest counter, which are dropped.
  task automatic test_slot_zero_and_drops();
    send_word(tkf_pkg::REQ_OFFER, 64'd2, rand_val());
    send_word(tkf_pkg::REQ_OFFER, 64'd2, rand_val());
    send_word(tkf_pkg::REQ_OFFER, 64'd1, KEY_ONES);
  endtask

  // Shift into the middle, then an offer equal to the top counter, which
  // stops one slot short of the top.
  task automatic test_shift_paths();
    send_word(tkf_pkg::REQ_OFFER, 64'd10, rand_val());
    send_word(tkf_pkg::REQ_OFFER, FREQ_MAX, 64'd0);
    send_word(tkf_pkg::REQ_READ, FREQ_MAX, KEY_ONES);
  endtask

  // Mostly rising frequencies so that inserts keep happening, with small ones
  // that tend to drop, full-width ones, the maximum and the odd readout.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned   n;
    int unsigned   pick;
    tkf_pkg::val_t freq;
    tkf_pkg::val_t key;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       key = 64'd0;
        1:       key = KEY_ONES;
        default: key = rand_val();
      endcase
      if (pick < 10) begin
        send_word(tkf_pkg::REQ_READ, rand_val(), key);
      end else begin
        if (pick < 55) begin
          rising_freq = rising_freq + tkf_pkg::val_t'($urandom_range(1, 8));
          freq = rising_freq;
        end else if (pick < 72) begin
          freq = tkf_pkg::val_t'($urandom_range(0, 40));
        end else if (pick < 92) begin
          freq = rand_val();
        end else begin
          freq = FREQ_MAX;
        end
        send_word(tkf_pkg::REQ_OFFER, freq, key);
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = tkf_pkg::REQ_OFFER;
    req_ch.freq     = '0;
    req_ch.key_id   = '0;
    rsp_ch.ready    = 1'b0;
    shadow_samples  = '0;
    foreach (shadow_counts[i]) begin
      shadow_counts[i] = '0;
      shadow_keys[i]   = '0;
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_empty_readout();
    test_fill_table();
    test_slot_zero_and_drops();
    test_shift_paths();
    // Let everything drain before the random part
    wait_drained();

    test_random_traffic(30);
    // Long stretch with both sides free of idling
    steady_flow = 1'b1;
    test_random_traffic(30);
    steady_flow = 1'b0;
    test_random_traffic(25);

    // Wait out the last words, then keep the clock running to catch stray words
    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- top_k_frequency_tracker.f -----
rtl/core/tkf_pkg.sv
rtl/core/tkf_if.sv
rtl/core/tkf_cell.sv
rtl/core/top_k_frequency_tracker.sv
sim/tb_top_k_frequency_tracker.sv
